@@ rtl/core/vrei_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vrei_pkg
// Shared types and constants of the voxel ray emission integrator.
// ---------------------------------------------------------------------------
package vrei_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDX,
    S_IDX_WAIT,
    S_GAP,
    S_TN_WAIT,
    S_TS_WAIT,
    S_RD,
    S_MUL0,
    S_MUL1,
    S_ACC,
    S_DONE
  } state_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_ZERO_DIR = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRACE = 1'b1;

  localparam logic [2:0] CFG_CELLS_X = 3'd0;
  localparam logic [2:0] CFG_CELLS_Y = 3'd1;
  localparam logic [2:0] CFG_CELLS_Z = 3'd2;
  localparam logic [2:0] CFG_SIDE_X  = 3'd3;
  localparam logic [2:0] CFG_SIDE_Y  = 3'd4;
  localparam logic [2:0] CFG_SIDE_Z  = 3'd5;

  localparam logic [63:0] SAT64 = '1;
  localparam int DIV_STEPS = 64;
  localparam int ADDR_DIM = 32;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/vrei_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vrei_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module vrei_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vrei_pkg::div_req_t req,
  output vrei_pkg::div_rsp_t      rsp
);
  import vrei_pkg::*;

  logic [31:0] rem_r;
  logic [63:0] quo_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem_r, quo_r[63]};
  assign fits    = shifted >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        quo_r <= {quo_r[62:0], fits};
        rem_r <= fits ? 32'(shifted - {1'b0, req.divisor}) : shifted[31:0];
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        quo_r  <= req.dividend;
        rem_r  <= '0;
        cnt_r  <= 7'(DIV_STEPS);
        busy_r <= 1'b1;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

@@ rtl/core/vrei_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vrei_store
// Emissivity memory, one write port and one registered read port.
// ---------------------------------------------------------------------------
module vrei_store #(
  parameter int AW = 17
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/voxel_ray_emission_integrator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// voxel_ray_emission_integrator_core
// Walks a ray through a voxel grid and sums distance times emissivity.
// ---------------------------------------------------------------------------
// The input channel carries load and trace transactions. A load writes one
// emissivity entry and produces no result. A trace produces one result
// transaction on the output channel.
// A trace runs on one shared 64-bit by 32-bit divider that retires one
// quotient bit per cycle: three divisions for the start cell, then two per
// axis with a nonzero direction. For each cell crossed the walk then reads
// the store, forms two 32x32 partial products and accumulates; in_stall
// stays high until the trace ends. A trace with a zero direction skips the
// divider, and one that starts outside the grid stops after the division
// that finds it outside.
// A finished result sits in the output register until it is taken; the
// block accepts the next transaction meanwhile and holds the next result
// back only while the previous one is still stalled.
// Write configuration over cfg_ only while idle; the block never checks.
// Reset restores the default grid and clears control state; the store is
// not cleared and must be loaded before it is traced.
// ---------------------------------------------------------------------------
module voxel_ray_emission_integrator_core #(
  parameter int GRID_DIM_MAX = 32,
  parameter int NUM_LINES    = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [14:0]        in_cell_address,
  input  wire logic [1:0]         in_line_select,
  input  wire logic [31:0]        in_emissivity,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [31:0] in_dir_x,
  input  wire logic signed [31:0] in_dir_y,
  input  wire logic signed [31:0] in_dir_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             out_total_emission,
  output logic [6:0]              out_cells_crossed,
  output logic [1:0]              out_trace_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import vrei_pkg::*;

  localparam int CELL_LIMIT = (GRID_DIM_MAX < ADDR_DIM) ? GRID_DIM_MAX : ADDR_DIM;
  localparam int AW = $clog2(ADDR_DIM * ADDR_DIM * ADDR_DIM * NUM_LINES);
  localparam logic [AW-1:0] NL = AW'(NUM_LINES);

  logic [5:0]  cells_r [3];
  logic [30:0] side_r  [3];
  logic [5:0]  cells_eff [3];
  logic [30:0] side_eff  [3];

  state_t             state_r, state_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic signed [31:0] org_r [3], org_nxt [3];
  logic signed [31:0] dir_r [3], dir_nxt [3];
  logic [1:0]         line_r, line_nxt;
  logic [5:0]         idx_r [3], idx_nxt [3];
  logic [63:0]        tnext_r [3], tnext_nxt [3];
  logic [63:0]        tstep_r [3], tstep_nxt [3];
  logic [63:0]        tnow_r, tnow_nxt;
  logic [63:0]        tmin_r, tmin_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [6:0]         crossed_r, crossed_nxt;
  logic [63:0]        p0_r, p0_nxt;
  logic [63:0]        p1_r, p1_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_total_r, out_total_nxt;
  logic [6:0]         out_crossed_r, out_crossed_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [31:0]   rd_data;
  logic [31:0]   emis;
  logic [63:0]   ds;
  logic [31:0]   mul_a;
  logic [63:0]   mul_p;
  logic [6:0]    gap_mult;
  logic [37:0]   gap_prod;
  logic signed [39:0] gap;
  logic [31:0]   mag;
  logic [31:0]   org_abs;
  logic          in_grid;
  logic [63:0]   tmin_c;
  logic [64:0]   hi_sum;
  logic [63:0]   prod;
  logic [64:0]   acc;
  logic [64:0]   tadd;
  logic          quo_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r[0] <= 6'd32;
      cells_r[1] <= 6'd32;
      cells_r[2] <= 6'd32;
      side_r[0]  <= 31'd65536;
      side_r[1]  <= 31'd65536;
      side_r[2]  <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CELLS_X: cells_r[0] <= cfg_data[5:0];
        CFG_CELLS_Y: cells_r[1] <= cfg_data[5:0];
        CFG_CELLS_Z: cells_r[2] <= cfg_data[5:0];
        CFG_SIDE_X:  side_r[0]  <= cfg_data[30:0];
        CFG_SIDE_Y:  side_r[1]  <= cfg_data[30:0];
        CFG_SIDE_Z:  side_r[2]  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cells_r[a] == 6'd0) begin
        cells_eff[a] = 6'd1;
      end else if (32'(cells_r[a]) > CELL_LIMIT) begin
        cells_eff[a] = 6'(CELL_LIMIT);
      end else begin
        cells_eff[a] = cells_r[a];
      end
      side_eff[a] = (side_r[a] == 31'd0) ? 31'd1 : side_r[a];
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign wr_en   = accept && (in_command == CMD_LOAD) && (32'(in_line_select) < NUM_LINES);
  assign wr_addr = AW'(in_cell_address) * NL + AW'(in_line_select);
  assign rd_en   = (state_r == S_RD);
  assign rd_addr = AW'({idx_r[2][4:0], idx_r[1][4:0], idx_r[0][4:0]}) * NL + AW'(line_r);

  vrei_store #(.AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_emissivity),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vrei_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign emis  = (32'(line_r) < NUM_LINES) ? rd_data : 32'd0;
  assign ds    = tmin_r - tnow_r;
  assign mul_a = (state_r == S_MUL0) ? ds[31:0] : ds[63:32];
  assign mul_p = 64'(mul_a) * 64'(emis);

  assign org_abs  = org_r[axis_r][31] ? 32'(-org_r[axis_r]) : org_r[axis_r];
  assign mag      = dir_r[axis_r][31] ? 32'(-dir_r[axis_r]) : dir_r[axis_r];
  assign gap_mult = dir_r[axis_r][31] ? {1'b0, idx_r[axis_r]} : 7'({1'b0, idx_r[axis_r]} + 7'd1);
  assign gap_prod = 38'(gap_mult) * 38'(side_eff[axis_r]);
  assign quo_out  = (org_r[axis_r][31] && (div_rsp.quotient != 64'd0)) ||
                    (div_rsp.quotient[63:6] != 58'd0) ||
                    (div_rsp.quotient[5:0] >= cells_eff[axis_r]);

  always_comb begin
    if (dir_r[axis_r][31]) begin
      gap = 40'(org_r[axis_r]) - $signed({2'b00, gap_prod});
    end else begin
      gap = $signed({2'b00, gap_prod}) - 40'(org_r[axis_r]);
    end
    if (gap < 0) begin
      gap = '0;
    end
  end

  always_comb begin
    in_grid = 1'b1;
    tmin_c  = SAT64;
    for (int a = 0; a < 3; a++) begin
      if (idx_r[a] >= cells_eff[a]) begin
        in_grid = 1'b0;
      end
      if ((dir_r[a] != 32'sd0) && (tnext_r[a] < tmin_c)) begin
        tmin_c = tnext_r[a];
      end
    end
  end

  assign hi_sum = 65'(p1_r) + 65'(p0_r[63:32]);
  assign prod   = (hi_sum[64:32] != 33'd0) ? SAT64 : {hi_sum[31:0], p0_r[31:0]};
  assign acc    = 65'(sum_r) + 65'(prod);

  always_comb begin
    state_nxt       = state_r;
    axis_nxt        = axis_r;
    org_nxt         = org_r;
    dir_nxt         = dir_r;
    line_nxt        = line_r;
    idx_nxt         = idx_r;
    tnext_nxt       = tnext_r;
    tstep_nxt       = tstep_r;
    tnow_nxt        = tnow_r;
    tmin_nxt        = tmin_r;
    sum_nxt         = sum_r;
    crossed_nxt     = crossed_r;
    p0_nxt          = p0_r;
    p1_nxt          = p1_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r;
    out_total_nxt   = out_total_r;
    out_crossed_nxt = out_crossed_r;
    out_status_nxt  = out_status_r;
    div_req.start    = 1'b0;
    div_req.dividend = {32'd0, org_abs};
    div_req.divisor  = {1'b0, side_eff[axis_r]};
    tadd             = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_TRACE)) begin
          org_nxt[0]  = in_origin_x;
          org_nxt[1]  = in_origin_y;
          org_nxt[2]  = in_origin_z;
          dir_nxt[0]  = in_dir_x;
          dir_nxt[1]  = in_dir_y;
          dir_nxt[2]  = in_dir_z;
          line_nxt    = in_line_select;
          axis_nxt    = 2'd0;
          sum_nxt     = '0;
          tnow_nxt    = '0;
          crossed_nxt = '0;
          if ((in_dir_x == 32'sd0) && (in_dir_y == 32'sd0) && (in_dir_z == 32'sd0)) begin
            status_nxt = ST_ZERO_DIR;
            state_nxt  = S_DONE;
          end else begin
            status_nxt = ST_OK;
            state_nxt  = S_IDX;
          end
        end
      end
      S_IDX: begin
        div_req.start = 1'b1;
        state_nxt     = S_IDX_WAIT;
      end
      S_IDX_WAIT: begin
        if (div_rsp.done) begin
          idx_nxt[axis_r] = div_rsp.quotient[5:0];
          if (quo_out) begin
            status_nxt = ST_OUTSIDE;
            state_nxt  = S_DONE;
          end else if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            state_nxt = S_GAP;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_IDX;
          end
        end
      end
      S_GAP: begin
        if (dir_r[axis_r] == 32'sd0) begin
          tnext_nxt[axis_r] = SAT64;
          tstep_nxt[axis_r] = '0;
          if (axis_r == 2'd2) begin
            state_nxt = S_RD;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {gap[33:0], 30'd0};
          div_req.divisor  = mag;
          state_nxt        = S_TN_WAIT;
        end
      end
      S_TN_WAIT: begin
        div_req.dividend = {3'd0, side_eff[axis_r], 30'd0};
        div_req.divisor  = mag;
        if (div_rsp.done) begin
          tnext_nxt[axis_r] = div_rsp.quotient;
          div_req.start     = 1'b1;
          state_nxt         = S_TS_WAIT;
        end
      end
      S_TS_WAIT: begin
        div_req.divisor = mag;
        if (div_rsp.done) begin
          tstep_nxt[axis_r] = div_rsp.quotient;
          if (axis_r == 2'd2) begin
            state_nxt = S_RD;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_GAP;
          end
        end
      end
      S_RD: begin
        if (in_grid) begin
          crossed_nxt = crossed_r + 7'd1;
          tmin_nxt    = tmin_c;
          state_nxt   = S_MUL0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL0: begin
        p0_nxt    = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p1_nxt    = mul_p;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt  = acc[64] ? SAT64 : acc[63:0];
        tnow_nxt = tmin_r;
        for (int a = 0; a < 3; a++) begin
          if ((dir_r[a] != 32'sd0) && (tnext_r[a] == tmin_r)) begin
            idx_nxt[a]   = dir_r[a][31] ? idx_r[a] - 6'd1 : idx_r[a] + 6'd1;
            tadd         = 65'(tnext_r[a]) + 65'(tstep_r[a]);
            tnext_nxt[a] = tadd[64] ? SAT64 : tadd[63:0];
          end
        end
        state_nxt = S_RD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_total_nxt   = (status_r == ST_OK) ? sum_r : 64'd0;
          out_crossed_nxt = (status_r == ST_OK) ? crossed_r : 7'd0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      crossed_r   <= '0;
      status_r    <= ST_OK;
      sum_r       <= '0;
      tnow_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      crossed_r   <= crossed_nxt;
      status_r    <= status_nxt;
      sum_r       <= sum_nxt;
      tnow_r      <= tnow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    org_r         <= org_nxt;
    dir_r         <= dir_nxt;
    line_r        <= line_nxt;
    idx_r         <= idx_nxt;
    tnext_r       <= tnext_nxt;
    tstep_r       <= tstep_nxt;
    tmin_r        <= tmin_nxt;
    p0_r          <= p0_nxt;
    p1_r          <= p1_nxt;
    out_total_r   <= out_total_nxt;
    out_crossed_r <= out_crossed_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_total_emission = out_total_r;
  assign out_cells_crossed  = out_crossed_r;
  assign out_trace_status   = out_status_r;

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_trace_status != ST_OK)) |->
      ((out_total_emission == 64'd0) && (out_cells_crossed == 7'd0)))
    else $error("failed trace reports nonzero totals");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_crossed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (crossed_r <= 7'd96))
    else $error("cell count beyond three grid spans");

endmodule
`default_nettype wire

@@ verif/tb_voxel_ray_emission_integrator_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_voxel_ray_emission_integrator_core
// Self-checking testbench for the voxel ray emission integrator. Load and
// trace transactions go in under random idling and stalls, a scoreboard
// walks each ray through its own copy of the grid and store, and every
// result transaction is compared field by field with its prediction.
// ---------------------------------------------------------------------------
module tb_voxel_ray_emission_integrator_core;
  import vrei_pkg::*;

  typedef struct {
    bit        cmd;
    bit [14:0] addr;
    bit [1:0]  line;
    bit [31:0] emis;
    bit [31:0] org [3];
    bit [31:0] dir [3];
  } item_t;

  typedef struct {
    bit [63:0] total;
    bit [6:0]  crossed;
    bit [1:0]  status;
  } result_t;

  class emission_scoreboard;
    bit [31:0] store [int];
    bit        planned [int];
    bit [5:0]  cells [3];
    bit [30:0] side [3];
    result_t   pending [$];
    int        errors;

    function new();
      foreach (cells[a]) begin
        cells[a] = 6'd32;
        side[a] = 31'd65536;
      end
    endfunction

    function void set_cfg(int idx, bit [31:0] val);
      if (idx < 3) cells[idx] = val[5:0];
      else side[idx - 3] = val[30:0];
    endfunction

    function longint grid_len(int a);
      longint c;
      c = cells[a];
      if (c < 1) c = 1;
      if (c > 32) c = 32;
      return c;
    endfunction

    function longint side_len(int a);
      return (side[a] == 0) ? 1 : longint'(side[a]);
    endfunction

    function bit in_grid(longint ix [3]);
      for (int a = 0; a < 3; a++)
        if (ix[a] < 0 || ix[a] >= grid_len(a)) return 0;
      return 1;
    endfunction

    // Walks one ray. In planning mode it only lists store entries that the
    // walk would read and that no load has been scheduled for yet.
    function void walk_ray(item_t it, bit plan_only, output result_t res,
                           ref int missing [$]);
      longint o [3], d [3], ix [3], gap, sd;
      bit [63:0] tn [3], ts [3], tnow, tmin, ds, emis, sum, mag, g, prod;
      bit [127:0] p;
      bit [64:0] s;
      int cnt, key;
      res = '{0, 0, ST_OK};
      sum = 0;
      tnow = 0;
      cnt = 0;
      for (int a = 0; a < 3; a++) begin
        o[a] = longint'($signed(it.org[a]));
        d[a] = longint'($signed(it.dir[a]));
      end
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
        res.status = ST_ZERO_DIR;
        return;
      end
      for (int a = 0; a < 3; a++) ix[a] = o[a] / side_len(a);
      if (!in_grid(ix)) begin
        res.status = ST_OUTSIDE;
        return;
      end
      for (int a = 0; a < 3; a++) begin
        tn[a] = '1;
        ts[a] = 0;
        if (d[a] != 0) begin
          sd = side_len(a);
          mag = (d[a] < 0) ? -d[a] : d[a];
          gap = (d[a] > 0) ? (ix[a] + 1) * sd - o[a] : o[a] - ix[a] * sd;
          if (gap < 0) gap = 0;
          g = gap;
          tn[a] = (g << 30) / mag;
          g = sd;
          ts[a] = (g << 30) / mag;
        end
      end
      while (in_grid(ix)) begin
        cnt++;
        tmin = '1;
        for (int a = 0; a < 3; a++)
          if (d[a] != 0 && tn[a] < tmin) tmin = tn[a];
        ds = tmin - tnow;
        key = int'((ix[0] + 32 * ix[1] + 1024 * ix[2]) * 4 + it.line);
        if (plan_only) begin
          if (!planned.exists(key)) begin
            planned[key] = 1;
            missing = {missing, key};
          end
        end else begin
          emis = store.exists(key) ? store[key] : 0;
          p = ds * emis;
          prod = (p[127:64] != 0) ? '1 : p[63:0];
          s = {1'b0, sum} + {1'b0, prod};
          sum = s[64] ? '1 : s[63:0];
        end
        tnow = tmin;
        for (int a = 0; a < 3; a++)
          if (d[a] != 0 && tn[a] == tmin) begin
            ix[a] += (d[a] > 0) ? 1 : -1;
            s = {1'b0, tn[a]} + {1'b0, ts[a]};
            tn[a] = s[64] ? '1 : s[63:0];
          end
      end
      res.total = sum;
      res.crossed = cnt[6:0];
    endfunction

    function void note_input(item_t it);
      result_t res;
      int none [$];
      if (it.cmd == CMD_LOAD) begin
        store[int'(it.addr) * 4 + it.line] = it.emis;
      end else begin
        walk_ray(it, 0, res, none);
        pending = {pending, res};
      end
    endfunction

    function void check_result(bit [63:0] total, bit [6:0] crossed, bit [1:0] status);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (total !== e.total) begin
        $error("total_emission expected %0h actual %0h", e.total, total);
        errors++;
      end
      if (crossed !== e.crossed) begin
        $error("cells_crossed expected %0d actual %0d", e.crossed, crossed);
        errors++;
      end
      if (status !== e.status) begin
        $error("trace_status expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_command = 0;
  logic [14:0] in_cell_address = 0;
  logic [1:0] in_line_select = 0;
  logic [31:0] in_emissivity = 0;
  logic signed [31:0] in_origin_x = 0, in_origin_y = 0, in_origin_z = 0;
  logic signed [31:0] in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] out_total_emission;
  logic [6:0] out_cells_crossed;
  logic [1:0] out_trace_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  emission_scoreboard sb = new();
  int snd_idle = 32;
  int rcv_idle = 84;
  int n_results = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  int n_items = 0;
  int n_traces = 0;

  voxel_ray_emission_integrator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_cell_address(in_cell_address),
    .in_line_select(in_line_select), .in_emissivity(in_emissivity),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_total_emission(out_total_emission), .out_cells_crossed(out_cells_crossed),
    .out_trace_status(out_trace_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    item_t it;
    if (rst_n && in_valid && !in_stall) begin
      it.cmd = in_command;
      it.addr = in_cell_address;
      it.line = in_line_select;
      it.emis = in_emissivity;
      it.org = '{in_origin_x, in_origin_y, in_origin_z};
      it.dir = '{in_dir_x, in_dir_y, in_dir_z};
      sb.note_input(it);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_total_emission, out_cells_crossed, out_trace_status);
      n_results++;
    end
  end

  // The long hold-off lets the block fill up while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_results == 8) begin
      hold_done <= 1'b1;
      hold_cnt <= 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  task automatic send(item_t it);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_command <= it.cmd;
    in_cell_address <= it.addr;
    in_line_select <= it.line;
    in_emissivity <= it.emis;
    in_origin_x <= it.org[0];
    in_origin_y <= it.org[1];
    in_origin_z <= it.org[2];
    in_dir_x <= it.dir[0];
    in_dir_y <= it.dir[1];
    in_dir_z <= it.dir[2];
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  task automatic send_load(bit [14:0] addr, bit [1:0] line, bit [31:0] emis);
    item_t it;
    it = '{default: 0};
    it.cmd = CMD_LOAD;
    it.addr = addr;
    it.line = line;
    it.emis = emis;
    it.org = '{$urandom, $urandom, $urandom};
    it.dir = '{$urandom, $urandom, $urandom};
    send(it);
  endtask

  // Schedules loads for unplanned entries the ray reads, then the trace.
  task automatic send_trace(bit [31:0] org [3], bit [31:0] dir [3], bit [1:0] line);
    item_t it;
    result_t res;
    int missing [$];
    bit [31:0] emis;
    it = '{default: 0};
    it.cmd = CMD_TRACE;
    it.line = line;
    it.org = org;
    it.dir = dir;
    it.addr = 15'($urandom);
    it.emis = $urandom;
    sb.walk_ray(it, 1, res, missing);
    foreach (missing[k]) begin
      case ($urandom_range(0, 7))
        0: emis = 0;
        1: emis = '1;
        default: emis = $urandom_range(0, 32'h0004_0000);
      endcase
      send_load(15'(missing[k] >> 2), missing[k][1:0], emis);
    end
    send(it);
    n_traces++;
  endtask

  task automatic write_cfg(logic [2:0] idx, bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cfg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_origin(int a);
    longint sd, n, v;
    sd = sb.side_len(a);
    n = sb.grid_len(a);
    case ($urandom_range(0, 9))
      0: v = longint'($signed($urandom));
      1: v = -longint'($urandom_range(0, 32'(sd - 1)));
      2: v = longint'($urandom_range(0, 32'(n))) * sd;
      default: v = longint'($urandom_range(0, 32'(n - 1))) * sd +
                   longint'($urandom_range(0, 32'(sd - 1)));
    endcase
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = longint'($signed($urandom));
    return v[31:0];
  endfunction

  function automatic bit [31:0] pick_dir();
    longint v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = $urandom_range(0, 1) ? 64'sd1073741824 : -64'sd1073741824;
      2: v = longint'($urandom_range(0, 64)) - 32;
      default: v = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
    endcase
    return v[31:0];
  endfunction

  task automatic random_traffic(int count);
    bit [31:0] org [3], dir [3];
    int goal, tgoal;
    bit [31:0] m;
    goal = n_items + count;
    tgoal = n_traces + 12;
    while (n_items < goal || n_traces < tgoal) begin
      case ($urandom_range(0, 19))
        0: send_load(15'($urandom), 2'($urandom), $urandom);
        1: begin
          org = '{$urandom, $urandom, $urandom};
          dir = '{$urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000, 0, 0};
          send_trace(org, dir, 2'($urandom));
        end
        2: send_trace('{pick_origin(0), pick_origin(1), pick_origin(2)},
                      '{0, 0, 0}, 2'($urandom));
        3: begin
          m = $urandom_range(1, 32'h4000_0000);
          for (int a = 0; a < 3; a++) begin
            org[a] = 32'(longint'($urandom_range(0, 32'(sb.grid_len(a) - 1))) *
                         sb.side_len(a));
            dir[a] = $urandom_range(0, 1) ? m : -m;
          end
          send_trace(org, dir, 2'($urandom));
        end
        default: begin
          for (int a = 0; a < 3; a++) begin
            org[a] = pick_origin(a);
            dir[a] = pick_dir();
          end
          send_trace(org, dir, 2'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    bit [31:0] cx [6], cy [6], cz [6], sx [6], sy [6], sz [6];
    cx = '{32, 0, 32, 4, 1, 32};
    cy = '{32, 63, 32, 7, 1, 32};
    cz = '{32, 5, 32, 3, 1, 32};
    sx = '{65536, 0, 1, $urandom_range(4096, 1 << 20), 65536, 5000};
    sy = '{65536, 32'h7FFF_FFFF, 1, $urandom_range(4096, 1 << 20), 65536, 70000};
    sz = '{65536, 3, 1, $urandom_range(4096, 1 << 20), 65536, 1 << 24};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_load(0, 0, 0);
    send_load(15'h7FFF, 3, 32'hFFFF_FFFF);
    send_load(0, 1, 32'hFFFF_FFFF);
    send_trace('{0, 0, 0}, '{0, 0, 0}, 0);
    send_trace('{32'h8000_0000, 0, 0}, '{32'h4000_0000, 0, 0}, 1);
    send_trace('{32'h7FFF_FFFF, 0, 0}, '{32'hC000_0000, 0, 0}, 2);
    send_trace('{0, 0, 0}, '{32'h4000_0000, 0, 0}, 0);
    send_trace('{0, 0, 0}, '{0, 32'h4000_0000, 0}, 1);
    send_trace('{0, 0, 0}, '{0, 0, 32'h4000_0000}, 2);
    send_trace('{32'h001F_8000, 32'h001F_8000, 32'h001F_8000},
               '{32'hC000_0000, 32'hC000_0000, 32'hC000_0000}, 3);
    send_trace('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
               '{32'h2000_0000, 32'h2000_0000, 32'h2000_0000}, 0);
    send_trace('{32'hFFFF_8000, 32'hFFFF_0001, 0},
               '{32'h3000_0000, 32'h1000_0000, 32'h0100_0000}, 1);
    send_trace('{32'h0000_8000, 32'h0000_8000, 32'h0000_8000}, '{1, 0, 0}, 1);
    send_trace('{32'h0010_0000, 32'h0008_0000, 32'h0004_0000},
               '{32'hF000_0000, 32'h3000_0000, 32'hE000_0000}, 3);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_cfg(CFG_CELLS_X, cx[ph]);
        write_cfg(CFG_CELLS_Y, cy[ph]);
        write_cfg(CFG_CELLS_Z, cz[ph]);
        write_cfg(CFG_SIDE_X, sx[ph]);
        write_cfg(CFG_SIDE_Y, sy[ph]);
        write_cfg(CFG_SIDE_Z, sz[ph]);
        cfg_valid <= 1'b0;
      end
      snd_idle = (ph < 2) ? 32 : (ph < 4) ? 84 : 0;
      rcv_idle = (ph < 2) ? 84 : (ph < 4) ? 32 : 0;
      random_traffic(100);
      drain();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/vrei_pkg.sv
rtl/core/vrei_div.sv
rtl/core/vrei_store.sv
rtl/core/voxel_ray_emission_integrator_core.sv
verif/tb_voxel_ray_emission_integrator_core.sv
